// File: rtl/vau_pkg.sv
package vau_pkg;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_USAGE  = 3'd1;
    localparam logic [2:0] ST_STRIDE     = 3'd2;
    localparam logic [2:0] ST_SIZE       = 3'd3;
    localparam logic [2:0] ST_BAD_FORMAT = 3'd4;

    // source format codes
    localparam logic [2:0] FMT_WORD4  = 3'd0;
    localparam logic [2:0] FMT_WORD2  = 3'd1;
    localparam logic [2:0] FMT_TEN    = 3'd2;
    localparam logic [2:0] FMT_BYTE3  = 3'd3;
    localparam logic [2:0] FMT_ARGB   = 3'd4;

    // usage codes
    localparam logic [2:0] USE_UV_LAST  = 3'd2;
    localparam logic [2:0] USE_TANGENT  = 3'd5;
    localparam logic [2:0] USE_COLOUR   = 3'd6;

    // configuration register indexes
    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_USAGE  = 2'd1;
    localparam logic [1:0] REG_STRIDE = 2'd2;

    localparam int NUM_LANES = 4;

    typedef enum logic [1:0] {
        LW_8,
        LW_10,
        LW_16
    } lane_width_t;

    typedef struct packed {
        logic [63:0] packed_vertex;
        logic        last_vertex;
    } vau_in_t;

    typedef struct packed {
        logic [31:0] comp_x;
        logic [31:0] comp_y;
        logic [31:0] comp_z;
        logic [31:0] comp_w;
        logic [2:0]  comp_count;
        logic [4:0]  out_stride;
        logic [2:0]  status;
        logic        last_out;
    } vau_out_t;

    typedef struct packed {
        logic [15:0] value;
        lane_width_t width;
        logic        is_signed;
    } lane_in_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

    typedef struct packed {
        logic [2:0] fmt;
        logic [3:0] mask;
        logic [2:0] count;
        logic [4:0] stride;
        logic [2:0] status;
    } check_t;

    typedef struct packed {
        logic [3:0] mask;
        logic [2:0] count;
        logic [4:0] stride;
        logic [2:0] status;
        logic       last;
    } side_t;

endpackage

// File: rtl/vau_check.sv
module vau_check
    import vau_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output check_t     chk
);

    logic [2:0] format_reg, format_next;
    logic [2:0] usage_reg, usage_next;
    logic [7:0] stride_reg, stride_next;

    // register writes
    always_comb
    begin
        format_next = format_reg;
        usage_next  = usage_reg;
        stride_next = stride_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FORMAT: format_next = cfg_data[2:0];
                REG_USAGE:  usage_next  = cfg_data[2:0];
                REG_STRIDE: stride_next = cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg <= FMT_WORD4;
            usage_reg  <= 3'd0;
            stride_reg <= 8'd8;
        end
        else
        begin
            format_reg <= format_next;
            usage_reg  <= usage_next;
            stride_reg <= stride_next;
        end
    end

    // usage decode and format checks
    always_comb
    begin
        logic [2:0] yields;
        logic [7:0] need_stride;
        logic [3:0] fmask;
        chk.fmt = format_reg;
        if (usage_reg <= USE_UV_LAST)
        begin
            chk.count = 3'd2; chk.stride = 5'd8;
        end
        else if (usage_reg <= USE_TANGENT)
        begin
            chk.count = 3'd3; chk.stride = 5'd12;
        end
        else if (usage_reg == USE_COLOUR)
        begin
            chk.count = 3'd4; chk.stride = 5'd16;
        end
        else
        begin
            chk.count = 3'd0; chk.stride = 5'd0;
        end
        need_stride = (format_reg == FMT_WORD4) ? 8'd8 : 8'd4;
        if (format_reg == FMT_WORD2)
        begin
            yields = 3'd2; fmask = 4'b0011;
        end
        else if (format_reg == FMT_ARGB)
        begin
            yields = 3'd4; fmask = 4'b1111;
        end
        else
        begin
            yields = 3'd3; fmask = 4'b0111;
        end
        priority if (chk.count == 3'd0)
            chk.status = ST_BAD_USAGE;
        else if (format_reg > FMT_ARGB)
            chk.status = ST_BAD_FORMAT;
        else if (stride_reg != need_stride)
            chk.status = ST_STRIDE;
        else if (chk.count != yields)
            chk.status = ST_SIZE;
        else
            chk.status = ST_OK;
        chk.mask = (chk.status == ST_OK) ? fmask : 4'b0000;
    end

endmodule

// File: rtl/vau_lane.sv
module vau_lane
    import vau_pkg::*;
(
    input  logic        clk,
    input  stage_en_t   en,
    input  lane_in_t    lin,
    output logic [31:0] result
);

    localparam logic [48:0] HALF = 49'h0_8000_0000_0000;
    localparam logic [48:0] ONE  = 49'h1_0000_0000_0000;

    logic        s1_zero_reg, s1_one_reg, s1_signed_reg;
    logic [23:0] s1_mant_reg;
    logic [3:0]  s1_lz_reg;
    logic        s2_signed_reg, s2_neg_reg;
    logic [31:0] s2_unorm_reg;
    logic [47:0] s2_mag_reg;
    logic [31:0] result_reg;

    // stage 1: v / (2^n - 1) as a repeating binary fraction, rounded to 24 bits
    logic [15:0] va;
    logic [47:0] rep;
    logic [49:0] rep10;
    logic        all_ones;
    logic [3:0]  lz16;
    logic [47:0] shifted;
    logic [24:0] mant25;

    always_comb
    begin
        rep10 = {5{lin.value[9:0]}};
        unique case (lin.width)
            LW_16:
            begin
                va = lin.value;
                rep = {3{lin.value}};
                all_ones = (lin.value == 16'hffff);
            end
            LW_10:
            begin
                va = {lin.value[9:0], 6'b0};
                rep = rep10[49:2];
                all_ones = (lin.value[9:0] == 10'h3ff);
            end
            LW_8:
            begin
                va = {lin.value[7:0], 8'b0};
                rep = {6{lin.value[7:0]}};
                all_ones = (lin.value[7:0] == 8'hff);
            end
            default:
            begin
                va = 16'd0;
                rep = 48'd0;
                all_ones = 1'b0;
            end
        endcase
        lz16 = 4'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (va[i])
                lz16 = 4'(15 - i);
        end
        shifted = rep << lz16;
        mant25 = shifted[47:23];
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            s1_zero_reg   <= (va == 16'd0);
            s1_one_reg    <= all_ones;
            s1_signed_reg <= lin.is_signed;
            s1_lz_reg     <= lz16;
            s1_mant_reg   <= mant25[24:1] + {23'd0, mant25[0]};
        end
    end

    // stage 2: unsigned float, or the exact value 2b - 1
    logic [48:0] fix2b;
    logic [48:0] diff;
    logic        neg;
    logic [31:0] unorm;

    always_comb
    begin
        if (s1_zero_reg)
            fix2b = 49'd0;
        else if (s1_one_reg)
            fix2b = ONE;
        else
            fix2b = {25'd0, s1_mant_reg} << (5'd24 - {1'b0, s1_lz_reg});
        neg  = (fix2b < HALF);
        diff = neg ? (HALF - fix2b) : (fix2b - HALF);
        if (s1_zero_reg)
            unorm = 32'd0;
        else if (s1_one_reg)
            unorm = 32'h3f80_0000;
        else
            unorm = {1'b0, 8'd126 - {4'd0, s1_lz_reg}, s1_mant_reg[22:0]};
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            s2_signed_reg <= s1_signed_reg;
            s2_neg_reg    <= neg;
            s2_mag_reg    <= diff[47:0];
            s2_unorm_reg  <= unorm;
        end
    end

    // stage 3: normalize and round to nearest even
    logic [5:0]  lz48;
    logic [47:0] norm;
    logic        round_up;
    logic [24:0] sum25;
    logic [31:0] snorm;

    always_comb
    begin
        lz48 = 6'd0;
        for (int i = 0; i < 48; i++)
        begin
            if (s2_mag_reg[i])
                lz48 = 6'(47 - i);
        end
        norm = s2_mag_reg << lz48;
        round_up = norm[23] & ((|norm[22:0]) | norm[24]);
        sum25 = {1'b0, norm[47:24]} + {24'd0, round_up};
        if (s2_mag_reg == 48'd0)
            snorm = 32'd0;
        else
            snorm = {s2_neg_reg,
                     8'd127 - {2'd0, lz48} + {7'd0, sum25[24]},
                     sum25[24] ? 23'd0 : sum25[22:0]};
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
            result_reg <= s2_signed_reg ? snorm : s2_unorm_reg;
    end

    assign result = result_reg;

endmodule

// File: rtl/vertex_attribute_unpack.sv
// vertex attribute unpack
// vtx channel: one packed source vertex per item (64 bits plus a last flag),
// taken at a clock edge with vtx_valid high and vtx_stall low.
// attr channel: one result item per vertex with four float components,
// component count, output stride, status and the copied last flag.
// The format, usage and declared stride come from the cfg write port; the
// user must write them only while no item is in flight (unchecked by the block).
// An accepted item passes the stage 1, 2 and 3 registers to attr_valid;
// throughput is one item per cycle while attr_stall is low. Four
// conversion lanes run side by side, each a three stage pipeline
// (fraction expansion, 2b-1 subtract, normalize and round); the last
// stage is the output register and the merge zeroes unused components.
// When the receiver stalls, the output item holds and earlier stages keep
// filling until every stage is occupied, then vtx_stall rises.
// Reset empties the pipeline and loads format 0, usage 0 and stride 8.
module vertex_attribute_unpack
    import vau_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       vtx_valid,
    output logic       vtx_stall,
    input  vau_in_t    vtx_data,
    output logic       attr_valid,
    input  logic       attr_stall,
    output vau_out_t   attr_data,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    check_t    chk;
    stage_en_t en;
    lane_in_t  lane_in [NUM_LANES];
    logic [31:0] lane_f [NUM_LANES];

    logic  v1_reg, v2_reg, v3_reg;
    side_t side1_reg, side2_reg, side3_reg;

    vau_check u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .chk       (chk)
    );

    // stage enables: a stage loads when it is empty or its successor moves
    always_comb
    begin
        en.s3 = !v3_reg || !attr_stall;
        en.s2 = !v2_reg || en.s3;
        en.s1 = !v1_reg || en.s2;
    end

    assign vtx_stall = !en.s1;

    // lane fields per format
    always_comb
    begin
        logic [31:0] w0;
        logic [31:0] w1;
        w0 = vtx_data.packed_vertex[31:0];
        w1 = vtx_data.packed_vertex[63:32];
        for (int i = 0; i < NUM_LANES; i++)
        begin
            lane_in[i].value     = 16'd0;
            lane_in[i].width     = LW_8;
            lane_in[i].is_signed = 1'b0;
        end
        unique case (chk.fmt)
            FMT_WORD4:
            begin
                lane_in[0] = '{w0[15:0], LW_16, 1'b1};
                lane_in[1] = '{w0[31:16], LW_16, 1'b1};
                lane_in[2] = '{w1[15:0], LW_16, 1'b1};
            end
            FMT_WORD2:
            begin
                lane_in[0] = '{w0[31:16], LW_16, 1'b0};
                lane_in[1] = '{w0[15:0], LW_16, 1'b0};
            end
            FMT_TEN:
            begin
                lane_in[0] = '{{6'd0, w0[9:0]}, LW_10, 1'b1};
                lane_in[1] = '{{6'd0, w0[19:10]}, LW_10, 1'b1};
                lane_in[2] = '{{6'd0, w0[29:20]}, LW_10, 1'b1};
            end
            FMT_BYTE3:
            begin
                lane_in[0] = '{{8'd0, w0[23:16]}, LW_8, 1'b0};
                lane_in[1] = '{{8'd0, w0[15:8]}, LW_8, 1'b0};
                lane_in[2] = '{{8'd0, w0[7:0]}, LW_8, 1'b0};
            end
            FMT_ARGB:
            begin
                lane_in[0] = '{{8'd0, w0[31:24]}, LW_8, 1'b0};
                lane_in[1] = '{{8'd0, w0[23:16]}, LW_8, 1'b0};
                lane_in[2] = '{{8'd0, w0[15:8]}, LW_8, 1'b0};
                lane_in[3] = '{{8'd0, w0[7:0]}, LW_8, 1'b0};
            end
            default: ;
        endcase
    end

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        vau_lane u_lane (
            .clk    (clk),
            .en     (en),
            .lin    (lane_in[g]),
            .result (lane_f[g])
        );
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en.s1) v1_reg <= vtx_valid;
            if (en.s2) v2_reg <= v1_reg;
            if (en.s3) v3_reg <= v2_reg;
        end
    end

    // sideband travels alongside the lanes
    always_ff @(posedge clk)
    begin
        if (en.s1)
            side1_reg <= '{chk.mask, chk.count, chk.stride, chk.status,
                           vtx_data.last_vertex};
        if (en.s2)
            side2_reg <= side1_reg;
        if (en.s3)
            side3_reg <= side2_reg;
    end

    // merge lanes into the result item
    always_comb
    begin
        attr_data.comp_x     = side3_reg.mask[0] ? lane_f[0] : 32'd0;
        attr_data.comp_y     = side3_reg.mask[1] ? lane_f[1] : 32'd0;
        attr_data.comp_z     = side3_reg.mask[2] ? lane_f[2] : 32'd0;
        attr_data.comp_w     = side3_reg.mask[3] ? lane_f[3] : 32'd0;
        attr_data.comp_count = side3_reg.count;
        attr_data.out_stride = side3_reg.stride;
        attr_data.status     = side3_reg.status;
        attr_data.last_out   = side3_reg.last;
    end

    assign attr_valid = v3_reg;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        attr_valid && attr_data.status != ST_OK |->
        attr_data.comp_x == 32'd0 && attr_data.comp_y == 32'd0 &&
        attr_data.comp_z == 32'd0 && attr_data.comp_w == 32'd0)
        else $error("error item carries components");

    a_bad_usage: assert property (@(posedge clk) disable iff (!rst_n)
        attr_valid && attr_data.status == ST_BAD_USAGE |->
        attr_data.comp_count == 3'd0 && attr_data.out_stride == 5'd0)
        else $error("bad usage with nonzero count");

    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !attr_stall |-> !vtx_stall)
        else $error("input stalled while output drains");

    a_uv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        attr_valid && attr_data.comp_count == 3'd2 |->
        attr_data.comp_z == 32'd0 && attr_data.comp_w == 32'd0)
        else $error("uv item with z or w set");

endmodule
